>>> sv/rc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rc_pkg: shared types and constants for the radix converter
// Word layouts, configuration register indexes and the controller/datapath
// command and status groups.
// ---------------------------------------------------------------------------
package rc_pkg;

  localparam int RADIX_W     = 6;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_FROM_BASE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TO_BASE   = 2'd1;

  localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
  localparam logic [RADIX_W-1:0] FROM_BASE_RST = 6'd10;
  localparam logic [RADIX_W-1:0] TO_BASE_RST   = 6'd2;

  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_COLON   = 8'd58;
  localparam logic [7:0] CHAR_AT      = 8'd64;
  localparam logic [7:0] CHAR_BRACKET = 8'd91;
  localparam logic [7:0] LETTER_BIAS  = 8'd55;
  localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       out_last;
    logic       overflow;
  } out_item_t;

  typedef struct packed {
    logic acc_en;       // fold accepted character into the value
    logic div_init;     // clear remainder and bit counter
    logic count_clear;  // restart digit count
    logic div_step;     // one restoring division bit
    logic digit_write;  // push remainder into digit memory
    logic rd_issue;     // read next digit, most significant first
    logic clear_num;    // drop value and overflow flag
  } rc_cmd_t;

  typedef struct packed {
    logic bit_last;
    logic quot_zero;
    logic count_zero;
  } rc_stat_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) res = RADIX_MIN;
    else if (r > RADIX_MAX) res = RADIX_MAX;
    else res = r;
    return res;
  endfunction

  function automatic logic [6:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [7:0] c;
    if (d < DEC_DIGITS) c = {2'b00, d} + CHAR_ZERO;
    else c = {2'b00, d} + LETTER_BIAS;
    return c[6:0];
  endfunction

endpackage
`default_nettype wire

>>> sv/rc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rc_ctrl: radix converter sequencer
// Takes characters while idle, then runs the division loop digit by digit
// and plays the stored digits back out, most significant first.
// ---------------------------------------------------------------------------
module rc_ctrl
  import rc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     in_last,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire rc_stat_t stat,
  output rc_cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_SEND  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc_en = 1'b1;
          if (in_last) begin
            cmd.div_init    = 1'b1;
            cmd.count_clear = 1'b1;
            state_next      = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.bit_last) state_next = ST_STORE;
      end
      ST_STORE: begin
        cmd.digit_write = 1'b1;
        cmd.div_init    = 1'b1;
        state_next      = stat.quot_zero ? ST_READ : ST_DIV;
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_SEND;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.count_zero) begin
            cmd.clear_num = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    $onehot0({in_ready, out_valid}))
    else $error("input and output active together");

  a_final_word_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND && out_ready && stat.count_zero) |=> in_ready)
    else $error("not idle after final digit");

  a_last_starts_div: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> cmd.div_step)
    else $error("conversion did not start");

endmodule
`default_nettype wire

>>> sv/rc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rc_datapath: radix converter value, divider and digit memory
// Multiply-add accumulator, one-bit-per-cycle restoring divider sharing the
// value register as quotient, digit memory and configuration registers.
// ---------------------------------------------------------------------------
module rc_datapath
  import rc_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [RADIX_W-1:0]     cfg_data,
  input  wire in_item_t               in_data,
  input  wire rc_cmd_t                cmd,
  output rc_stat_t                    stat,
  output out_item_t                   out_data
);

  localparam int BW = $clog2(VALUE_WIDTH);
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int AW = $clog2(MAX_DIGITS);
  localparam int PW = VALUE_WIDTH + RADIX_W;

  logic [RADIX_W-1:0]     from_base;
  logic [RADIX_W-1:0]     to_base;
  logic [VALUE_WIDTH-1:0] acc;
  logic                   ovf;
  logic [RADIX_W-1:0]     rem;
  logic [BW-1:0]          bitcnt;
  logic [CW-1:0]          dcount;
  logic [RADIX_W-1:0]     mem [MAX_DIGITS];
  logic [RADIX_W-1:0]     mem_q;

  logic [RADIX_W-1:0] fb;
  logic [RADIX_W-1:0] tb;
  logic               dig_ok;
  logic [7:0]         dig_wide;
  logic [RADIX_W-1:0] dig;
  logic [PW-1:0]      prod;
  logic [PW:0]        wide;
  logic               ovf_now;
  logic [RADIX_W:0]   rem_sh;
  logic               ge;
  logic [RADIX_W:0]   rem_sub;
  logic [CW-1:0]      dcount_dec;
  logic               has_room;

  assign fb = clamp_radix(from_base);
  assign tb = clamp_radix(to_base);

  always_comb begin
    dig_ok   = 1'b0;
    dig_wide = '0;
    if (in_data.in_char >= CHAR_ZERO && in_data.in_char < CHAR_COLON) begin
      dig_ok   = 1'b1;
      dig_wide = in_data.in_char - CHAR_ZERO;
    end else if (in_data.in_char > CHAR_AT && in_data.in_char < CHAR_BRACKET) begin
      dig_ok   = 1'b1;
      dig_wide = in_data.in_char - LETTER_BIAS;
    end
  end
  assign dig = dig_wide[RADIX_W-1:0];

  // the value overflows when anything lands above the kept width
  assign prod    = PW'(acc) * PW'(fb);
  assign wide    = (PW + 1)'(prod) + (PW + 1)'(dig);
  assign ovf_now = |wide[PW:VALUE_WIDTH];

  assign rem_sh  = {rem, acc[VALUE_WIDTH-1]};
  assign ge      = rem_sh >= {1'b0, tb};
  assign rem_sub = ge ? (rem_sh - {1'b0, tb}) : rem_sh;

  assign dcount_dec = dcount - 1'b1;
  assign has_room   = dcount < CW'(MAX_DIGITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      from_base <= FROM_BASE_RST;
      to_base   <= TO_BASE_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FROM_BASE) from_base <= cfg_data;
      if (cfg_index == CFG_TO_BASE) to_base <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      ovf    <= 1'b0;
      dcount <= '0;
    end else begin
      if (cmd.acc_en && dig_ok) begin
        acc <= wide[VALUE_WIDTH-1:0];
        if (ovf_now) ovf <= 1'b1;
      end else if (cmd.div_step) begin
        acc <= {acc[VALUE_WIDTH-2:0], ge};
      end else if (cmd.clear_num) begin
        acc <= '0;
        ovf <= 1'b0;
      end
      if (cmd.count_clear) begin
        dcount <= '0;
      end else if (cmd.digit_write && has_room) begin
        dcount <= dcount + 1'b1;
      end else if (cmd.rd_issue) begin
        dcount <= dcount_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem    <= '0;
      bitcnt <= '0;
    end else if (cmd.div_step) begin
      rem    <= rem_sub[RADIX_W-1:0];
      bitcnt <= bitcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.digit_write && has_room) mem[dcount[AW-1:0]] <= rem;
    if (cmd.rd_issue) mem_q <= mem[dcount_dec[AW-1:0]];
  end

  assign stat.bit_last   = bitcnt == BW'(VALUE_WIDTH - 1);
  assign stat.quot_zero  = acc == '0;
  assign stat.count_zero = dcount == '0;

  assign out_data.out_char = digit_char(mem_q);
  assign out_data.out_last = dcount == '0;
  assign out_data.overflow = ovf;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    dcount <= CW'(MAX_DIGITS))
    else $error("digit count past memory depth");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> rem < tb)
    else $error("remainder not below radix");

  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> dcount != '0)
    else $error("digit read with empty memory");

endmodule
`default_nettype wire

>>> sv/radix_converter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// radix_converter_core: ASCII number radix converter
// Folds digit characters into a value in from_base and emits the value as
// ASCII digits in to_base, most significant first.
//
//   port group   direction  word
//   in_*         sink       in_item_t   one character, last flag
//   out_*        source     out_item_t  one digit, last flag, overflow
//   cfg_*        sink       index/data  0: from_base, 1: to_base
//
// A character without the last flag is folded in and input stays ready for
// the next one. A last character starts the conversion: each digit comes
// from the one-bit-per-cycle restoring divider, then each digit leaves
// through a registered digit memory read, the next once out_ready takes it.
// Input is held off from the last character until the final digit is taken.
// Synchronous reset; no clearing pass. Config writes are always taken.
// ---------------------------------------------------------------------------
module radix_converter_core
  import rc_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_item_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_item_t                   out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [RADIX_W-1:0]     cfg_data
);

  rc_cmd_t  cmd;
  rc_stat_t stat;

  assign cfg_ready = 1'b1;

  rc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_last   (in_data.in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
